>>> src/i2cr_pkg.sv
// Shared types, codes and helper functions of the I2C target command responder.
package i2cr_pkg;

   // Default length of the block store and of the block write payload.
   localparam int BLOCK_LEN_DEF = 65;

   // Width of the write index, the read pointer and the remaining count.
   localparam int CNT_W = 8;

   // Bus event codes carried by the command field.
   typedef enum logic [2:0] {
      CMD_ADDR_MATCH = 3'd0,
      CMD_RX_BYTE    = 3'd1,
      CMD_TX_READY   = 3'd2,
      CMD_STOP       = 3'd3,
      CMD_SET_STATUS = 3'd4
   } cmd_type;

   // Command bytes sent by the controller.
   localparam logic [7:0] OP_WRITE_BLOCK  = 8'h10;
   localparam logic [7:0] OP_READ_BLOCK   = 8'h11;
   localparam logic [7:0] OP_WRITE_SINGLE = 8'h12;
   localparam logic [7:0] OP_READ_VERSION = 8'h13;
   localparam logic [7:0] OP_READ_STATUS  = 8'h14;

   // Reply lengths and the byte sent once a reply is used up.
   localparam logic [7:0] SINGLE_LEN        = 8'h02;
   localparam logic [7:0] VERSION_REPLY_LEN = 8'h0A;
   localparam logic [7:0] STATUS_REPLY_LEN  = 8'h02;
   localparam logic [7:0] VERSION_DATA_LEN  = 8'h09;
   localparam logic [7:0] FILL_BYTE         = 8'hFF;

   // Reply sources.
   typedef enum logic [1:0] {
      SRC_BLOCK   = 2'd0,
      SRC_VERSION = 2'd1,
      SRC_STATUS  = 2'd2,
      SRC_NONE    = 2'd3
   } src_type;

   // Parser phase, one-hot.
   typedef enum logic [2:0] {
      PH_CMD  = 3'b001,
      PH_LEN  = 3'b010,
      PH_DATA = 3'b100
   } phase_type;

   // Phase codes as seen on the result channel.
   localparam logic [1:0] PHASE_CODE_CMD  = 2'd0;
   localparam logic [1:0] PHASE_CODE_LEN  = 2'd1;
   localparam logic [1:0] PHASE_CODE_DATA = 2'd2;

   // Register indexes of the configuration port.
   localparam logic CSR_VERSION_LOW = 1'b0;
   localparam logic CSR_VERSION_TOP = 1'b1;

   // Write port of the block store.
   typedef struct packed {
      logic       en;
      logic [7:0] addr;
      logic [7:0] data;
   } store_wr_type;

   // Version byte k of the nine version bytes.
   function automatic logic [7:0] version_byte(input logic [63:0] low, input logic [7:0] top,
                                               input logic [3:0] k);
      logic [7:0] b;
      case (k)
         4'd0: b = low[7:0];
         4'd1: b = low[15:8];
         4'd2: b = low[23:16];
         4'd3: b = low[31:24];
         4'd4: b = low[39:32];
         4'd5: b = low[47:40];
         4'd6: b = low[55:48];
         4'd7: b = low[63:56];
         default: b = top;
      endcase
      return b;
   endfunction

   // Check byte of the version reply: XOR of the nine version bytes.
   function automatic logic [7:0] version_check(input logic [63:0] low, input logic [7:0] top);
      logic [7:0] x;
      x = top;
      for (int k = 0; k < 8; k++) begin
         x = x ^ low[8*k +: 8];
      end
      return x;
   endfunction

   // Map the one-hot phase onto its result code.
   function automatic logic [1:0] phase_code(input phase_type ph);
      logic [1:0] c;
      case (ph)
         PH_LEN:  c = PHASE_CODE_LEN;
         PH_DATA: c = PHASE_CODE_DATA;
         default: c = PHASE_CODE_CMD;
      endcase
      return c;
   endfunction

endpackage

>>> src/i2c_target_command_responder_core.sv
// Top level of the I2C target command responder: event parser, reply sequencer and ports.
//
// Usage: the bus layer presents one event per transaction on the req_ channel (address
// match with direction, received byte, transmit ready, stop, set status). Every event
// yields exactly one result transaction on the rsp_ channel carrying the byte to load
// into the transmit register, the armed flag, the parser phase and the write-done flag.
// The csr_ channel writes the version bytes; it is always ready and should be used only
// while no event is in flight.
// Timing: an accepted event waits in the input register and is processed once the result
// register is free; its result is then registered. Throughput is one event per cycle while
// the receiver takes results, set by the single registered pass from the input register to
// the result register; the block store is read ahead at the next read pointer so its
// registered read port keeps pace.
// Reset clears the parser to command wait, disarms any reply, zeroes the status, the
// version registers and the block store (through valid bits), and empties both stages.
// When the receiver holds rsp_ready low, the result stays put, one more event waits in
// the input register, and req_ready then drops until the result is taken.
module i2c_target_command_responder_core
   import i2cr_pkg::*;
#(
   parameter int BLOCK_LEN = BLOCK_LEN_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // Event channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_command,
   input  logic        req_read_direction,
   input  logic [7:0]  req_rx_byte,
   input  logic [7:0]  req_new_status,
   // Result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_tx_load,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_reply_armed,
   output logic [1:0]  rsp_parse_phase,
   output logic        rsp_write_done,
   // Configuration channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [63:0] csr_wdata
);

   localparam int ADDR_W = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 1;
   localparam logic [CNT_W-1:0] BLOCK_LEN_C = CNT_W'(BLOCK_LEN);
   localparam logic [CNT_W-1:0] BLOCK_LAST_C = CNT_W'(BLOCK_LEN - 1);

   // Configuration registers
   logic [63:0] version_low_ff;
   logic [7:0]  version_top_ff;

   // Input register
   logic        a_valid_ff;
   logic [2:0]  a_command_ff;
   logic        a_dir_ff;
   logic [7:0]  a_rx_ff;
   logic [7:0]  a_status_ff;
   logic        advance;

   // Parser and reply state
   phase_type        phase_ff, phase_in;
   logic [7:0]       exp_len_ff, exp_len_in;
   logic             wr_target_ff, wr_target_in;
   logic [CNT_W-1:0] wr_index_ff, wr_index_in;
   src_type          rd_src_ff, rd_src_in;
   logic [CNT_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] rd_rem_ff, rd_rem_in;
   logic             armed_ff, armed_in;
   logic [7:0]       status_ff, status_in;

   // Result register
   logic        rsp_valid_ff;
   logic        tx_load_ff, tx_load_in;
   logic [7:0]  tx_byte_ff, tx_byte_in;
   logic        done_ff, done_in;

   // Block store interface
   store_wr_type      store_wr;
   logic [ADDR_W-1:0] store_rd_addr;
   logic [7:0]        store_rd_byte;
   logic [7:0]        store_first_byte;
   logic [7:0]        cur_byte;
   logic [CNT_W-1:0]  wr_index_next;

   // Configuration writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         version_low_ff <= 64'h0;
         version_top_ff <= 8'h00;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_VERSION_LOW: version_low_ff <= csr_wdata;
            CSR_VERSION_TOP: version_top_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // The event in the input register is processed when the result register is free.
   assign advance   = a_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !a_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         a_valid_ff <= 1'b1;
      end else if (advance) begin
         a_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         a_command_ff <= req_command;
         a_dir_ff     <= req_read_direction;
         a_rx_ff      <= req_rx_byte;
         a_status_ff  <= req_new_status;
      end
   end

   // Reply byte at the current read pointer, from the live source.
   always_comb begin
      case (rd_src_ff)
         SRC_BLOCK: begin
            cur_byte = (rd_ptr_ff < BLOCK_LEN_C) ? store_rd_byte : FILL_BYTE;
         end
         SRC_VERSION: begin
            if (rd_ptr_ff < CNT_W'(VERSION_DATA_LEN)) begin
               cur_byte = version_byte(version_low_ff, version_top_ff, rd_ptr_ff[3:0]);
            end else if (rd_ptr_ff == CNT_W'(VERSION_DATA_LEN)) begin
               cur_byte = version_check(version_low_ff, version_top_ff);
            end else begin
               cur_byte = FILL_BYTE;
            end
         end
         SRC_STATUS: begin
            cur_byte = (rd_ptr_ff < CNT_W'(STATUS_REPLY_LEN)) ? status_ff : FILL_BYTE;
         end
         default: cur_byte = FILL_BYTE;
      endcase
   end

   assign wr_index_next = wr_index_ff + CNT_W'(1);

   // Event processing: next state and result of the event in the input register.
   always_comb begin
      phase_in     = phase_ff;
      exp_len_in   = exp_len_ff;
      wr_target_in = wr_target_ff;
      wr_index_in  = wr_index_ff;
      rd_src_in    = rd_src_ff;
      rd_ptr_in    = rd_ptr_ff;
      rd_rem_in    = rd_rem_ff;
      armed_in     = armed_ff;
      status_in    = status_ff;
      tx_load_in   = 1'b0;
      tx_byte_in   = 8'h00;
      done_in      = 1'b0;
      store_wr     = '0;
      if (advance) begin
         case (a_command_ff)
            CMD_ADDR_MATCH: begin
               if (a_dir_ff) begin
                  // Read address while disarmed sends filler.
                  if (!armed_ff) begin
                     tx_load_in = 1'b1;
                     tx_byte_in = FILL_BYTE;
                     rd_rem_in  = '0;
                  end
               end else begin
                  phase_in  = PH_CMD;
                  armed_in  = 1'b0;
                  rd_rem_in = '0;
               end
            end
            CMD_RX_BYTE: begin
               case (phase_ff)
                  PH_LEN: begin
                     if (a_rx_ff == exp_len_ff) begin
                        wr_index_in = '0;
                        phase_in    = PH_DATA;
                     end else begin
                        phase_in = PH_CMD;
                     end
                  end
                  PH_DATA: begin
                     // Single-store payload bytes are counted; no reply reads them.
                     if (!wr_target_ff && (wr_index_ff < BLOCK_LEN_C)) begin
                        store_wr.en   = 1'b1;
                        store_wr.addr = 8'(wr_index_ff);
                        store_wr.data = a_rx_ff;
                     end
                     wr_index_in = wr_index_next;
                     if (wr_index_next >= CNT_W'(exp_len_ff)) begin
                        phase_in = PH_CMD;
                        done_in  = 1'b1;
                     end
                  end
                  default: begin
                     // Command byte.
                     phase_in = PH_CMD;
                     case (a_rx_ff)
                        OP_READ_BLOCK: begin
                           rd_src_in  = SRC_BLOCK;
                           tx_load_in = 1'b1;
                           tx_byte_in = store_first_byte;
                           rd_ptr_in  = CNT_W'(1);
                           rd_rem_in  = BLOCK_LAST_C;
                           armed_in   = 1'b1;
                        end
                        OP_READ_VERSION: begin
                           rd_src_in  = SRC_VERSION;
                           tx_load_in = 1'b1;
                           tx_byte_in = version_low_ff[7:0];
                           rd_ptr_in  = CNT_W'(1);
                           rd_rem_in  = CNT_W'(VERSION_REPLY_LEN - 8'd1);
                           armed_in   = 1'b1;
                        end
                        OP_READ_STATUS: begin
                           rd_src_in  = SRC_STATUS;
                           tx_load_in = 1'b1;
                           tx_byte_in = status_ff;
                           rd_ptr_in  = CNT_W'(1);
                           rd_rem_in  = CNT_W'(STATUS_REPLY_LEN - 8'd1);
                           armed_in   = 1'b1;
                        end
                        OP_WRITE_BLOCK: begin
                           exp_len_in   = 8'(BLOCK_LEN);
                           wr_target_in = 1'b0;
                           phase_in     = PH_LEN;
                        end
                        OP_WRITE_SINGLE: begin
                           exp_len_in   = SINGLE_LEN;
                           wr_target_in = 1'b1;
                           phase_in     = PH_LEN;
                        end
                        default: ;
                     endcase
                  end
               endcase
            end
            CMD_TX_READY: begin
               tx_load_in = 1'b1;
               if (rd_rem_ff != '0) begin
                  tx_byte_in = cur_byte;
                  rd_ptr_in  = rd_ptr_ff + CNT_W'(1);
                  rd_rem_in  = rd_rem_ff - CNT_W'(1);
               end else begin
                  tx_byte_in = FILL_BYTE;
                  armed_in   = 1'b0;
               end
            end
            CMD_STOP: begin
               phase_in  = PH_CMD;
               armed_in  = 1'b0;
               rd_rem_in = '0;
            end
            CMD_SET_STATUS: begin
               status_in = a_status_ff;
            end
            default: ;
         endcase
      end
   end

   // The store is read ahead at the pointer that the next event will use.
   assign store_rd_addr = (rd_ptr_in < BLOCK_LEN_C) ? rd_ptr_in[ADDR_W-1:0] : '0;

   i2cr_block_store #(
      .BLOCK_LEN (BLOCK_LEN),
      .ADDR_W    (ADDR_W)
   ) u_block_store (
      .clock      (clock),
      .reset      (reset),
      .wr         (store_wr),
      .rd_addr    (store_rd_addr),
      .rd_byte    (store_rd_byte),
      .first_byte (store_first_byte)
   );

   // Parser and reply state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_CMD;
         exp_len_ff   <= 8'h00;
         wr_target_ff <= 1'b0;
         wr_index_ff  <= '0;
         rd_src_ff    <= SRC_BLOCK;
         rd_ptr_ff    <= '0;
         rd_rem_ff    <= '0;
         armed_ff     <= 1'b0;
         status_ff    <= 8'h00;
      end else begin
         phase_ff     <= phase_in;
         exp_len_ff   <= exp_len_in;
         wr_target_ff <= wr_target_in;
         wr_index_ff  <= wr_index_in;
         rd_src_ff    <= rd_src_in;
         rd_ptr_ff    <= rd_ptr_in;
         rd_rem_ff    <= rd_rem_in;
         armed_ff     <= armed_in;
         status_ff    <= status_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         tx_load_ff <= tx_load_in;
         tx_byte_ff <= tx_byte_in;
         done_ff    <= done_in;
      end
   end

   logic       armed_out_ff;
   logic [1:0] phase_out_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         armed_out_ff <= armed_in;
         phase_out_ff <= phase_code(phase_in);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_tx_load     = tx_load_ff;
   assign rsp_tx_byte     = tx_byte_ff;
   assign rsp_reply_armed = armed_out_ff;
   assign rsp_parse_phase = phase_out_ff;
   assign rsp_write_done  = done_ff;

endmodule

>>> src/i2cr_block_store.sv
// Block store memory with per-entry valid bits, write bypass and a copy of entry zero.
module i2cr_block_store
   import i2cr_pkg::*;
#(
   parameter int BLOCK_LEN = BLOCK_LEN_DEF,
   parameter int ADDR_W    = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  store_wr_type      wr,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_byte,
   output logic [7:0]        first_byte
);

   logic [7:0]           mem [BLOCK_LEN];
   logic [BLOCK_LEN-1:0] valid_ff;
   logic [BLOCK_LEN-1:0] valid_in;
   logic [7:0]           rd_data_ff;
   logic                 rd_valid_ff;
   logic                 rd_valid_in;
   logic [7:0]           first_ff;
   logic [ADDR_W-1:0]    wr_addr;
   logic                 wr_hit;

   assign wr_addr = wr.addr[ADDR_W-1:0];
   assign wr_hit  = wr.en && (wr_addr == rd_addr);

   // An entry counts as written once its valid bit is set; unwritten entries read as zero.
   always_comb begin
      valid_in = valid_ff;
      if (wr.en) begin
         valid_in[wr_addr] = 1'b1;
      end
      rd_valid_in = valid_ff[rd_addr] || wr_hit;
   end

   // Memory write and registered read, with the same-cycle write forwarded.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr_addr] <= wr.data;
      end
      if (wr_hit) begin
         rd_data_ff <= wr.data;
      end else begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Valid bits and the entry-zero copy used by the first byte of a block reply.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
         first_ff    <= 8'h00;
      end else begin
         valid_ff    <= valid_in;
         rd_valid_ff <= rd_valid_in;
         if (wr.en && (wr_addr == '0)) begin
            first_ff <= wr.data;
         end
      end
   end

   assign rd_byte    = rd_valid_ff ? rd_data_ff : 8'h00;
   assign first_byte = first_ff;

endmodule

>>> verif/testbench.sv
// Self-checking testbench for the I2C target command responder core.
`timescale 1ns / 100ps

module testbench;
   import i2cr_pkg::*;

   localparam int BLOCK_BYTES = BLOCK_LEN_DEF;

   // Event codes beyond the defined set, which the block must ignore.
   localparam logic [2:0] CMD_RESERVED_FIRST = 3'd5;
   localparam logic [2:0] CMD_RESERVED_LAST  = 3'd7;

   // One planned transaction: either a bus event or a version register write.
   typedef struct {
      bit         is_csr;
      logic [2:0] command;
      bit         dir;
      bit [7:0]   rx;
      bit [7:0]   ns;
      bit         csr_idx;
      bit [63:0]  csr_data;
   } bus_item_type;

   // What the block reports for one bus event.
   typedef struct packed {
      bit       load;
      bit [7:0] tx;
      bit       armed;
      bit [1:0] ph;
      bit       done;
   } bus_reply_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_command = CMD_STOP;
   logic        req_read_direction = 1'b0;
   logic [7:0]  req_rx_byte = 8'h00;
   logic [7:0]  req_new_status = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_tx_load;
   logic [7:0]  rsp_tx_byte;
   logic        rsp_reply_armed;
   logic [1:0]  rsp_parse_phase;
   logic        rsp_write_done;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = CSR_VERSION_LOW;
   logic [63:0] csr_wdata = 64'h0;

   i2c_target_command_responder_core u_top (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   bus_item_type  bus_events[$];
   bus_reply_type expected_replies[$];
   int            planned_events;
   int            events_accepted;
   int            error_count;
   bit            req_taken;
   bit            csr_taken;
   int            hold_left;
   int            next_hold_at = 100;

   // Shadow copy of the responder state and its version registers.
   bit [7:0]   blk_mem [BLOCK_BYTES];
   bit [7:0]   single_mem [2];
   bit [7:0]   status_reg;
   bit [1:0]   parse_ph = PHASE_CODE_CMD;
   bit [7:0]   want_len;
   bit         to_single;
   bit [7:0]   wr_idx;
   src_type    rd_src = SRC_BLOCK;
   bit [7:0]   rd_ptr;
   bit [7:0]   rd_left;
   bit         armed;
   bit [63:0]  ver_low;
   bit [7:0]   ver_top;

   function automatic bit [7:0] version_data_byte(int k);
      return (k < 8) ? ver_low[8*k +: 8] : ver_top;
   endfunction

   // Reply bytes are taken from the live stores at the moment they are loaded.
   function automatic bit [7:0] reply_byte_at(src_type src, bit [7:0] p);
      bit [7:0] b;
      b = FILL_BYTE;
      case (src)
         SRC_BLOCK: begin
            if (p < BLOCK_BYTES) b = blk_mem[p];
         end
         SRC_VERSION: begin
            if (p < VERSION_DATA_LEN) begin
               b = version_data_byte(p);
            end else if (p == VERSION_DATA_LEN) begin
               b = 8'h00;
               for (int k = 0; k < VERSION_DATA_LEN; k++) b ^= version_data_byte(k);
            end
         end
         SRC_STATUS: begin
            if (p < STATUS_REPLY_LEN) b = status_reg;
         end
         default: b = FILL_BYTE;
      endcase
      return b;
   endfunction

   // Advance the shadow state by one bus event and return what the block should report.
   function automatic bus_reply_type respond_to_event(bus_item_type ev);
      bus_reply_type r;
      src_type       src;
      int            len;
      r = '0;
      case (ev.command)
         CMD_ADDR_MATCH: begin
            if (ev.dir) begin
               if (!armed) begin
                  r.load = 1'b1;
                  r.tx = FILL_BYTE;
                  rd_left = 8'h00;
               end
            end else begin
               parse_ph = PHASE_CODE_CMD;
               armed = 1'b0;
               rd_left = 8'h00;
            end
         end
         CMD_RX_BYTE: begin
            if (parse_ph == PHASE_CODE_LEN) begin
               if (ev.rx == want_len) begin
                  wr_idx = 8'h00;
                  parse_ph = PHASE_CODE_DATA;
               end else begin
                  parse_ph = PHASE_CODE_CMD;
               end
            end else if (parse_ph == PHASE_CODE_DATA) begin
               if (!to_single && wr_idx < BLOCK_BYTES) blk_mem[wr_idx] = ev.rx;
               if (to_single && wr_idx < SINGLE_LEN) single_mem[wr_idx] = ev.rx;
               wr_idx = wr_idx + 8'd1;
               if (wr_idx >= want_len) begin
                  parse_ph = PHASE_CODE_CMD;
                  r.done = 1'b1;
               end
            end else begin
               // Command byte: a read arms a reply, a write waits for its length.
               parse_ph = PHASE_CODE_CMD;
               src = SRC_NONE;
               len = 0;
               case (ev.rx)
                  OP_READ_BLOCK: begin
                     src = SRC_BLOCK;
                     len = BLOCK_BYTES;
                  end
                  OP_READ_VERSION: begin
                     src = SRC_VERSION;
                     len = VERSION_REPLY_LEN;
                  end
                  OP_READ_STATUS: begin
                     src = SRC_STATUS;
                     len = STATUS_REPLY_LEN;
                  end
                  default: src = SRC_NONE;
               endcase
               if (src != SRC_NONE) begin
                  rd_src = src;
                  r.load = 1'b1;
                  r.tx = reply_byte_at(src, 8'h00);
                  rd_ptr = 8'h01;
                  rd_left = 8'(len - 1);
                  armed = 1'b1;
               end else if (ev.rx == OP_WRITE_BLOCK) begin
                  want_len = 8'(BLOCK_BYTES);
                  to_single = 1'b0;
                  parse_ph = PHASE_CODE_LEN;
               end else if (ev.rx == OP_WRITE_SINGLE) begin
                  want_len = SINGLE_LEN;
                  to_single = 1'b1;
                  parse_ph = PHASE_CODE_LEN;
               end
            end
         end
         CMD_TX_READY: begin
            r.load = 1'b1;
            if (rd_left > 0) begin
               r.tx = reply_byte_at(rd_src, rd_ptr);
               rd_ptr = rd_ptr + 8'd1;
               rd_left = rd_left - 8'd1;
            end else begin
               r.tx = FILL_BYTE;
               armed = 1'b0;
            end
         end
         CMD_STOP: begin
            parse_ph = PHASE_CODE_CMD;
            armed = 1'b0;
            rd_left = 8'h00;
         end
         CMD_SET_STATUS: status_reg = ev.ns;
         default: r = '0;
      endcase
      r.armed = armed;
      r.ph = parse_ph;
      return r;
   endfunction

   // Fields that an event does not use are filled with random values.
   task automatic add_evt(logic [2:0] cmd, bit dir, bit [7:0] rx, bit [7:0] ns);
      bus_item_type ev;
      ev.is_csr = 1'b0;
      ev.command = cmd;
      ev.dir = (cmd == CMD_ADDR_MATCH) ? dir : 1'($urandom_range(1));
      ev.rx = (cmd == CMD_RX_BYTE) ? rx : 8'($urandom_range(255));
      ev.ns = (cmd == CMD_SET_STATUS) ? ns : 8'($urandom_range(255));
      ev.csr_idx = CSR_VERSION_LOW;
      ev.csr_data = 64'h0;
      bus_events.push_back(ev);
      planned_events++;
   endtask

   task automatic add_rx(bit [7:0] rx);
      add_evt(CMD_RX_BYTE, 1'b0, rx, 8'h00);
   endtask

   task automatic add_csr(bit idx, bit [63:0] data);
      bus_item_type ev;
      ev = '{default: '0};
      ev.is_csr = 1'b1;
      ev.command = CMD_STOP;
      ev.csr_idx = idx;
      ev.csr_data = data;
      bus_events.push_back(ev);
   endtask

   // Write transaction; a bad length or dropped payload bytes make a broken one.
   task automatic plan_write(bit single, bit bad_length, int drop);
      bit [7:0] len;
      bit [7:0] wrong;
      len = single ? SINGLE_LEN : 8'(BLOCK_BYTES);
      add_evt(CMD_ADDR_MATCH, 1'b0, 8'h00, 8'h00);
      add_rx(single ? OP_WRITE_SINGLE : OP_WRITE_BLOCK);
      if (bad_length) begin
         wrong = 8'($urandom_range(255));
         if (wrong == len) wrong = ~wrong;
         add_rx(wrong);
         repeat ($urandom_range(2)) add_rx(8'($urandom_range(255)));
      end else begin
         add_rx(len);
         repeat (int'(len) - drop) add_rx(8'($urandom_range(255)));
      end
      if ($urandom_range(4) != 0) add_evt(CMD_STOP, 1'b0, 8'h00, 8'h00);
   endtask

   // Read transaction: command byte, usually the repeated read address, then pulls.
   task automatic plan_read(bit [7:0] op);
      int len;
      int pulls;
      len = (op == OP_READ_BLOCK) ? BLOCK_BYTES :
            (op == OP_READ_VERSION) ? int'(VERSION_REPLY_LEN) : int'(STATUS_REPLY_LEN);
      pulls = ($urandom_range(5) == 0) ? len + 1 : $urandom_range(3);
      add_evt(CMD_ADDR_MATCH, 1'b0, 8'h00, 8'h00);
      add_rx(op);
      if ($urandom_range(3) != 0) add_evt(CMD_ADDR_MATCH, 1'b1, 8'h00, 8'h00);
      repeat (pulls) add_evt(CMD_TX_READY, 1'b0, 8'h00, 8'h00);
      if ($urandom_range(4) != 0) add_evt(CMD_STOP, 1'b0, 8'h00, 8'h00);
   endtask

   function automatic bit [7:0] any_opcode();
      bit [7:0] op;
      case ($urandom_range(4))
         0: op = OP_WRITE_BLOCK;
         1: op = OP_READ_BLOCK;
         2: op = OP_WRITE_SINGLE;
         3: op = OP_READ_VERSION;
         default: op = OP_READ_STATUS;
      endcase
      return op;
   endfunction

   // Mostly well-formed transactions with random content, plus noise and broken ones.
   task automatic plan_random(int count);
      int stop_at;
      int pick;
      stop_at = planned_events + count;
      while (planned_events < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 6) begin
            plan_write(1'b0, 1'b0, ($urandom_range(3) == 0) ? $urandom_range(1, 64) : 0);
         end else if (pick < 21) begin
            plan_write(1'b1, 1'b0, ($urandom_range(3) == 0) ? 1 : 0);
         end else if (pick < 61) begin
            case ($urandom_range(2))
               0: plan_read(OP_READ_BLOCK);
               1: plan_read(OP_READ_VERSION);
               default: plan_read(OP_READ_STATUS);
            endcase
         end else if (pick < 71) begin
            add_evt(CMD_SET_STATUS, 1'b0, 8'h00, 8'($urandom_range(255)));
         end else if (pick < 81) begin
            plan_write(1'($urandom_range(1)), 1'b1, 0);
         end else begin
            add_evt(3'($urandom_range(7)), 1'($urandom_range(1)),
                    $urandom_range(1) ? any_opcode() : 8'($urandom_range(255)),
                    8'($urandom_range(255)));
         end
      end
   endtask

   // Random idling on both sides, switched off for one long stretch of the run.
   function automatic bit idle_roll();
      if (events_accepted >= 150 && events_accepted < 260) return 1'b0;
      return $urandom_range(99) < 14;
   endfunction

   task automatic compare_field(string name, logic [7:0] want_v, logic [7:0] got_v);
      if (got_v !== want_v) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
      end
   endtask

   // Event and register write driver, changing inputs on the falling edge.
   always @(negedge clock) begin : drive_requests
      bit offer;
      bit issue_csr;
      offer = 1'b0;
      issue_csr = 1'b0;
      if (!reset) begin
         if (!req_valid || req_taken) begin
            if (bus_events.size() > 0 && !bus_events[0].is_csr &&
                !(csr_valid && !csr_taken) && !idle_roll()) begin
               offer = 1'b1;
               req_command <= bus_events[0].command;
               req_read_direction <= bus_events[0].dir;
               req_rx_byte <= bus_events[0].rx;
               req_new_status <= bus_events[0].ns;
               void'(bus_events.pop_front());
            end
            req_valid <= offer;
         end
         // Register writes go out only once every expected transaction has come back.
         if (!csr_valid || csr_taken) begin
            if (bus_events.size() > 0 && bus_events[0].is_csr && !offer &&
                !(req_valid && !req_taken) && expected_replies.size() == 0) begin
               issue_csr = 1'b1;
               csr_index <= bus_events[0].csr_idx;
               csr_wdata <= bus_events[0].csr_data;
               void'(bus_events.pop_front());
            end
            csr_valid <= issue_csr;
         end
      end
   end

   // Result-side ready, with long hold-offs that back the block up into its input.
   always @(negedge clock) begin : drive_ready
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (events_accepted >= next_hold_at) begin
         next_hold_at += 220;
         hold_left = 40;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !idle_roll();
      end
   end

   // Sample handshakes on the rising edge, predict accepted events, check results.
   always @(posedge clock) begin : watch_ports
      bus_item_type  ev;
      bus_reply_type want;
      if (reset) begin
         req_taken = 1'b0;
         csr_taken = 1'b0;
      end else begin
         req_taken = req_valid && req_ready;
         csr_taken = csr_valid && csr_ready;
         if (csr_taken) begin
            if (csr_index == CSR_VERSION_LOW) ver_low = csr_wdata;
            else ver_top = csr_wdata[7:0];
         end
         if (req_taken) begin
            ev = '{default: '0};
            ev.command = req_command;
            ev.dir = req_read_direction;
            ev.rx = req_rx_byte;
            ev.ns = req_new_status;
            expected_replies.push_back(respond_to_event(ev));
            events_accepted++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_replies.size() == 0) begin
               error_count++;
               $display("%0t: result transaction with none expected, tx_byte %0h",
                        $time, rsp_tx_byte);
            end else begin
               want = expected_replies.pop_front();
               compare_field("tx_load", want.load, rsp_tx_load);
               compare_field("tx_byte", want.tx, rsp_tx_byte);
               compare_field("reply_armed", want.armed, rsp_reply_armed);
               compare_field("parse_phase", want.ph, rsp_parse_phase);
               compare_field("write_done", want.done, rsp_write_done);
            end
         end
      end
   end

   // Stimulus plan, reset, and end of run.
   initial begin
      add_csr(CSR_VERSION_LOW, 64'hF0E1_D2C3_B4A5_9687);
      add_csr(CSR_VERSION_TOP, 64'h0000_0000_0000_003C);

      // Read address while idle sends the fill byte.
      add_evt(CMD_ADDR_MATCH, 1'b1, 8'h00, 8'h00);
      add_evt(CMD_SET_STATUS, 1'b0, 8'h00, 8'hA5);
      // Status reply, the read address while armed, then past the end.
      add_evt(CMD_ADDR_MATCH, 1'b0, 8'h00, 8'h00);
      add_rx(OP_READ_STATUS);
      add_evt(CMD_ADDR_MATCH, 1'b1, 8'h00, 8'h00);
      repeat (2) add_evt(CMD_TX_READY, 1'b0, 8'h00, 8'h00);
      add_evt(CMD_STOP, 1'b0, 8'h00, 8'h00);
      // Single store write with extreme payload bytes.
      add_evt(CMD_ADDR_MATCH, 1'b0, 8'h00, 8'h00);
      add_rx(OP_WRITE_SINGLE);
      add_rx(SINGLE_LEN);
      add_rx(8'h00);
      add_rx(8'hFF);
      // Length mismatch, then an unknown command byte.
      add_rx(OP_WRITE_BLOCK);
      add_rx(8'h40);
      add_rx(8'h00);
      for (int c = CMD_RESERVED_FIRST; c <= CMD_RESERVED_LAST; c++)
         add_evt(3'(c), 1'b1, 8'hFF, 8'hFF);
      add_rx(OP_READ_VERSION);
      repeat (2) add_evt(CMD_TX_READY, 1'b0, 8'h00, 8'h00);
      add_evt(CMD_STOP, 1'b0, 8'h00, 8'h00);
      add_rx(OP_READ_BLOCK);
      add_evt(CMD_TX_READY, 1'b0, 8'h00, 8'h00);

      // Random phases under all-ones, all-zeros and random version settings.
      add_csr(CSR_VERSION_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
      add_csr(CSR_VERSION_TOP, 64'h0000_0000_0000_00FF);
      plan_random(135);
      add_csr(CSR_VERSION_LOW, 64'h0);
      add_csr(CSR_VERSION_TOP, 64'h0);
      plan_random(135);
      add_csr(CSR_VERSION_LOW, {32'($urandom), 32'($urandom)});
      add_csr(CSR_VERSION_TOP, {32'($urandom), 32'($urandom)});
      plan_random(135);

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (bus_events.size() != 0 || req_valid || csr_valid ||
             expected_replies.size() != 0)
         @(negedge clock);
      repeat (5) @(negedge clock);
      if (error_count == 0 && expected_replies.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #200us;
      $display("Regression FAIL");
      $finish;
   end

endmodule

>>> filelist.f
src/i2cr_pkg.sv
src/i2cr_block_store.sv
src/i2c_target_command_responder_core.sv
verif/testbench.sv
